FILE: design/stereo_peak_hold_meter_macros.svh
// Assertion helpers for the meter RTL.
`ifndef STEREO_PEAK_HOLD_METER_MACROS_SVH
`define STEREO_PEAK_HOLD_METER_MACROS_SVH

// Same-cycle implication.
`define SPHM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/spk_pkg.sv
package spk_pkg;

   localparam int CHANNELS = 2;

   localparam int LEVEL_W = 16;
   localparam int TIME_W  = 32;
   localparam int CSR_W   = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int DROP_W  = 18;
   localparam int STEP_W  = 4;
   localparam int EXP_W   = 31;
   localparam int STEPS   = 16;

   localparam logic OP_LEVEL = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FLOOR_DB   = 2'd0,
      CSR_HOLD_TIME  = 2'd1,
      CSR_DECAY_RATE = 2'd2
   } csr_index_type;

   localparam logic [CSR_W-1:0] FLOOR_RESET = 16'hC400;
   localparam logic [CSR_W-1:0] HOLD_RESET  = 16'd1000;
   localparam logic [CSR_W-1:0] DECAY_RESET = 16'd5120;

   // drop = floor(rate * elapsed / 1000), clipped: any drop this large kills a peak
   localparam logic [DROP_W-1:0] DROP_MAX       = 18'd131072;
   localparam logic [47:0]       DROP_SAT_LIMIT = 48'd131072000;
   localparam logic [27:0]       RECIP_1000     = 28'd137438954;

   // log2 -> dB and dB -> log2 scale factors
   localparam logic [19:0] LOG2_BIAS   = 20'd983040;
   localparam logic [19:0] DB_PER_LOG2 = 20'd394566;
   localparam logic [22:0] LOG2_PER_DB = 23'd2786635;

   localparam logic [LEVEL_W-1:0] REFRESH_STEP = 16'd33;

   typedef enum logic [1:0] {
      T_IDLE,
      T_RUN,
      T_OUT
   } top_state_type;

   typedef enum logic [3:0] {
      L_IDLE,
      L_LOG,
      L_DB,
      L_LOW,
      L_CMP,
      L_TQ,
      L_EXP,
      L_GAIN,
      L_UPD
   } lane_state_type;

   typedef struct packed {
      logic                start;
      logic                clear;
      logic                decay_en;
      logic [TIME_W-1:0]   now_ms;
      logic [CSR_W-1:0]    floor_db;
      logic [CSR_W-1:0]    hold_time_ms;
      logic [DROP_W-1:0]   drop;
      logic                drop_valid;
   } lane_cmd_type;

   typedef struct packed {
      logic               done;
      logic               refresh;
      logic [LEVEL_W-1:0] peak;
   } lane_rsp_type;

   typedef logic [EXP_W-1:0] exp_tab_type [STEPS];

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] probe;
      rem = v;
      res = '0;
      for (int i = 31; i >= 0; i--) begin
         probe = 64'd1 << (2 * i);
         if (rem >= res + probe) begin
            rem = rem - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // Q30 factors 2^(2^-k), k = 1..16, each the isqrt of the previous one
   function automatic exp_tab_type make_exp_tab();
      exp_tab_type t;
      logic [63:0] c;
      c = isqrt64(64'd2 << 60);
      t[0] = c[EXP_W-1:0];
      for (int k = 1; k < STEPS; k++) begin
         c = isqrt64(c << 30);
         t[k] = c[EXP_W-1:0];
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = make_exp_tab();

endpackage

FILE: design/spk_drop.sv
module spk_drop (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [spk_pkg::TIME_W-1:0]  elapsed,
   input  logic [spk_pkg::CSR_W-1:0]   decay_rate,
   output logic [spk_pkg::DROP_W-1:0]  drop,
   output logic                        valid
);

   logic [spk_pkg::TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [47:0]                prod_ff, prod_in;
   logic                       sat_ff, sat_in;
   logic [54:0]                quot_ff, quot_in;
   logic [spk_pkg::DROP_W-1:0] drop_ff, drop_in;
   logic [2:0]                 stage_ff, stage_in;
   logic                       valid_ff, valid_in;

   always_comb begin
      elapsed_in = start ? elapsed : elapsed_ff;
      prod_in    = {16'd0, elapsed_ff} * {32'd0, decay_rate};
      sat_in     = prod_ff >= spk_pkg::DROP_SAT_LIMIT;
      quot_in    = {28'd0, prod_ff[26:0]} * {27'd0, spk_pkg::RECIP_1000};
      drop_in    = drop_ff;
      if (stage_ff[2]) begin
         drop_in = sat_ff ? spk_pkg::DROP_MAX : quot_ff[54:37];
      end
      stage_in = {stage_ff[1:0], start};
      valid_in = start ? 1'b0 : (valid_ff | stage_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         valid_ff <= valid_in;
      end
      elapsed_ff <= elapsed_in;
      prod_ff    <= prod_in;
      sat_ff     <= sat_in;
      quot_ff    <= quot_in;
      drop_ff    <= drop_in;
   end

   assign drop  = drop_ff;
   assign valid = valid_ff;

endmodule

FILE: design/spk_lane.sv
module spk_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  spk_pkg::lane_cmd_type        cmd,
   input  logic [spk_pkg::LEVEL_W-1:0]  level,
   output spk_pkg::lane_rsp_type        rsp
);

   spk_pkg::lane_state_type state_ff, state_in;

   logic [15:0] peak_ff, peak_in;
   logic [15:0] shown_ff, shown_in;
   logic [31:0] peak_time_ff, peak_time_in;
   logic [15:0] level_ff, level_in;
   logic [31:0] now_ff, now_in;
   logic        done_ff, done_in;
   logic        refresh_ff, refresh_in;
   logic        decay_ff, decay_in;
   logic [15:0] m_ff, m_in;
   logic [15:0] frac_ff, frac_in;
   logic [3:0]  msb_ff, msb_in;
   logic [spk_pkg::STEP_W-1:0] step_ff, step_in;
   logic signed [41:0] prod_ff, prod_in;
   logic signed [16:0] cur_ff, cur_in;
   logic signed [18:0] low_ff, low_in;
   logic signed [41:0] tq_ff, tq_in;
   logic [spk_pkg::EXP_W-1:0] r_ff, r_in;
   logic [15:0] dec_ff, dec_in;

   logic [3:0]  msb;
   logic [15:0] norm;
   logic [31:0] age;
   logic        go;
   logic [31:0] sq;
   logic [16:0] sq_top;
   logic signed [20:0] x;
   logic signed [41:0] x_ext;
   logic signed [41:0] biased;
   logic signed [16:0] db;
   logic signed [16:0] fl17;
   logic signed [18:0] fl19;
   logic signed [18:0] low;
   logic               kill;
   logic signed [41:0] low_ext;
   logic [15:0] f;
   logic [61:0] rc;
   logic signed [9:0]  n;
   logic signed [10:0] sh;
   logic [spk_pkg::EXP_W-1:0] g;
   logic [15:0] gain;
   logic [15:0] cur_pk;
   logic [15:0] new_pk;
   logic        take;

   function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   always_comb begin
      msb = '0;
      for (int i = 0; i < 16; i++) begin
         if (peak_ff[i]) msb = 4'(i);
      end
   end

   assign norm = peak_ff << (4'd15 - msb);
   assign age  = cmd.now_ms - peak_time_ff;
   assign go   = cmd.decay_en && (peak_ff != '0) && (age >= {16'd0, cmd.hold_time_ms});

   // log2 squaring step
   assign sq     = {16'd0, m_ff} * {16'd0, m_ff};
   assign sq_top = sq[31:15];

   // log2 -> dB, floor clamp
   assign x      = $signed({1'b0, msb_ff, frac_ff}) - $signed({1'b0, spk_pkg::LOG2_BIAS});
   assign x_ext  = 42'(x);
   assign biased = prod_ff + $signed(42'd8388608);
   assign db     = biased[40:24];
   assign fl17   = 17'($signed(cmd.floor_db));
   assign fl19   = 19'($signed(cmd.floor_db));

   assign low     = 19'(cur_ff) - $signed({1'b0, cmd.drop});
   assign kill    = low <= fl19;
   assign low_ext = 42'(low_ff);

   // dB -> gain
   assign f  = tq_ff[31:16];
   assign n  = tq_ff[41:32];
   assign sh = 11'sd15 - 11'(n);
   assign rc = {31'd0, r_ff} * {31'd0, spk_pkg::EXP_TAB[step_ff]};
   assign g  = r_ff >> sh[4:0];

   always_comb begin
      if (sh < 11'sd0) begin
         gain = 16'hFFFF;
      end else if (sh > 11'sd31) begin
         gain = '0;
      end else if (g > 31'd65535) begin
         gain = 16'hFFFF;
      end else begin
         gain = g[15:0];
      end
   end

   assign cur_pk = decay_ff ? dec_ff : peak_ff;
   assign take   = level_ff >= cur_pk;
   assign new_pk = take ? level_ff : cur_pk;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spk_pkg::L_IDLE: begin
            if (cmd.start) begin
               if (cmd.clear) begin
                  state_in = spk_pkg::L_IDLE;
               end else if (go) begin
                  state_in = spk_pkg::L_LOG;
               end else begin
                  state_in = spk_pkg::L_UPD;
               end
            end
         end
         spk_pkg::L_LOG: begin
            if (step_ff == 4'(spk_pkg::STEPS - 1)) state_in = spk_pkg::L_DB;
         end
         spk_pkg::L_DB:  state_in = spk_pkg::L_LOW;
         spk_pkg::L_LOW: state_in = spk_pkg::L_CMP;
         spk_pkg::L_CMP: begin
            if (cmd.drop_valid) begin
               state_in = kill ? spk_pkg::L_UPD : spk_pkg::L_TQ;
            end
         end
         spk_pkg::L_TQ:  state_in = spk_pkg::L_EXP;
         spk_pkg::L_EXP: begin
            if (step_ff == 4'(spk_pkg::STEPS - 1)) state_in = spk_pkg::L_GAIN;
         end
         spk_pkg::L_GAIN: state_in = spk_pkg::L_UPD;
         spk_pkg::L_UPD:  state_in = spk_pkg::L_IDLE;
         default:         state_in = spk_pkg::L_IDLE;
      endcase
   end

   always_comb begin
      peak_in      = peak_ff;
      shown_in     = shown_ff;
      peak_time_in = peak_time_ff;
      level_in     = level_ff;
      now_in       = now_ff;
      done_in      = 1'b0;
      refresh_in   = refresh_ff;
      decay_in     = decay_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      msb_in       = msb_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      cur_in       = cur_ff;
      low_in       = low_ff;
      tq_in        = tq_ff;
      r_in         = r_ff;
      dec_in       = dec_ff;
      case (state_ff)
         spk_pkg::L_IDLE: begin
            if (cmd.start) begin
               level_in = level;
               now_in   = cmd.now_ms;
               decay_in = go;
               m_in     = norm;
               msb_in   = msb;
               frac_in  = '0;
               step_in  = '0;
               if (cmd.clear) begin
                  peak_in    = '0;
                  done_in    = 1'b1;
                  refresh_in = 1'b1;
               end
            end
         end
         spk_pkg::L_LOG: begin
            if (sq_top[16]) begin
               m_in    = sq_top[16:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               m_in    = sq_top[15:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
         end
         spk_pkg::L_DB: begin
            prod_in = x_ext * $signed({22'd0, spk_pkg::DB_PER_LOG2});
         end
         spk_pkg::L_LOW: begin
            cur_in = (db < fl17) ? fl17 : db;
         end
         spk_pkg::L_CMP: begin
            low_in = low;
            if (kill) dec_in = '0;
         end
         spk_pkg::L_TQ: begin
            tq_in   = low_ext * $signed({19'd0, spk_pkg::LOG2_PER_DB});
            r_in    = 31'd1 << 30;
            step_in = '0;
         end
         spk_pkg::L_EXP: begin
            if (f[~step_ff]) r_in = rc[60:30];
            step_in = step_ff + 4'd1;
         end
         spk_pkg::L_GAIN: begin
            dec_in = gain;
         end
         spk_pkg::L_UPD: begin
            peak_in  = new_pk;
            shown_in = level_ff;
            if (take) peak_time_in = now_ff;
            refresh_in = (abs_diff(shown_ff, level_ff) >= spk_pkg::REFRESH_STEP) ||
                         (abs_diff(peak_ff, new_pk) >= spk_pkg::REFRESH_STEP);
            done_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spk_pkg::L_IDLE;
         peak_ff      <= '0;
         shown_ff     <= '0;
         peak_time_ff <= '0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         peak_ff      <= peak_in;
         shown_ff     <= shown_in;
         peak_time_ff <= peak_time_in;
         done_ff      <= done_in;
      end
      refresh_ff <= refresh_in;
      level_ff   <= level_in;
      now_ff     <= now_in;
      decay_ff   <= decay_in;
      m_ff       <= m_in;
      frac_ff    <= frac_in;
      msb_ff     <= msb_in;
      step_ff    <= step_in;
      prod_ff    <= prod_in;
      cur_ff     <= cur_in;
      low_ff     <= low_in;
      tq_ff      <= tq_in;
      r_ff       <= r_in;
      dec_ff     <= dec_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.refresh = refresh_ff;
   assign rsp.peak    = peak_ff;

endmodule

FILE: design/stereo_peak_hold_meter.sv
// Channel   Ports                          Dir  Handshake
// request   req_opcode/now_ms/level_*      in   req_valid / req_ready
// response  rsp_peak_left/right, refresh   out  rsp_valid / rsp_ready
// csr       csr_index, csr_wdata           in   csr_we, no wait
//
// Level request with a decaying peak: two 16-step loops in each lane (log2,
// then 2^x); the 2^x loop is skipped if the peak falls to the floor.
// Level request without decay and clear request: neither loop runs.
// One request at a time; req_ready returns once the result is in the output
// register, which holds it while rsp_ready is low.
// Synchronous reset restores register defaults and zeroes the peaks held in the lanes.
`include "stereo_peak_hold_meter_macros.svh"

module stereo_peak_hold_meter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [spk_pkg::TIME_W-1:0]        req_now_ms,
   input  logic [spk_pkg::LEVEL_W-1:0]       req_level_left,
   input  logic [spk_pkg::LEVEL_W-1:0]       req_level_right,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spk_pkg::LEVEL_W-1:0]       rsp_peak_left,
   output logic [spk_pkg::LEVEL_W-1:0]       rsp_peak_right,
   output logic                              rsp_refresh,
   input  logic                              csr_we,
   input  logic [spk_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spk_pkg::CSR_W-1:0]         csr_wdata
);

   spk_pkg::top_state_type state_ff, state_in;

   logic [spk_pkg::CSR_W-1:0]    floor_ff, floor_in;
   logic [spk_pkg::CSR_W-1:0]    hold_ff, hold_in;
   logic [spk_pkg::CSR_W-1:0]    rate_ff, rate_in;
   logic                         started_ff, started_in;
   logic [spk_pkg::TIME_W-1:0]   last_time_ff, last_time_in;
   logic [spk_pkg::CHANNELS-1:0] done_seen_ff, done_seen_in;
   logic                         refresh_acc_ff, refresh_acc_in;
   logic                         op_ff, op_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [spk_pkg::LEVEL_W-1:0]  rsp_peak_left_ff, rsp_peak_left_in;
   logic [spk_pkg::LEVEL_W-1:0]  rsp_peak_right_ff, rsp_peak_right_in;
   logic                         rsp_refresh_ff, rsp_refresh_in;

   logic                         accept;
   logic                         level_op;
   logic [spk_pkg::TIME_W-1:0]   elapsed;
   logic [spk_pkg::DROP_W-1:0]   drop_value;
   logic                         drop_valid;
   logic                         all_done;
   logic                         out_free;
   logic                         load_out;
   logic [spk_pkg::LEVEL_W-1:0]  peak_right_src;

   spk_pkg::lane_cmd_type        lane_cmd;
   spk_pkg::lane_rsp_type        lane_rsp [spk_pkg::CHANNELS];
   logic [spk_pkg::CHANNELS-1:0] lane_done;
   logic [spk_pkg::CHANNELS-1:0] lane_refresh;

   assign accept   = req_valid && req_ready;
   assign level_op = req_opcode == spk_pkg::OP_LEVEL;
   assign elapsed  = req_now_ms - last_time_ff;

   spk_drop u_drop (
      .clock      (clock),
      .reset      (reset),
      .start      (accept && level_op),
      .elapsed    (elapsed),
      .decay_rate (rate_ff),
      .drop       (drop_value),
      .valid      (drop_valid)
   );

   assign lane_cmd.start        = accept;
   assign lane_cmd.clear        = !level_op;
   assign lane_cmd.decay_en     = started_ff;
   assign lane_cmd.now_ms       = req_now_ms;
   assign lane_cmd.floor_db     = floor_ff;
   assign lane_cmd.hold_time_ms = hold_ff;
   assign lane_cmd.drop         = drop_value;
   assign lane_cmd.drop_valid   = drop_valid;

   for (genvar ch = 0; ch < spk_pkg::CHANNELS; ch++) begin : g_lane
      logic [spk_pkg::LEVEL_W-1:0] lane_level;
      if (ch == 0) begin : g_left
         assign lane_level = req_level_left;
      end else if (ch == 1) begin : g_right
         assign lane_level = req_level_right;
      end else begin : g_extra
         assign lane_level = '0;
      end

      spk_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cmd   (lane_cmd),
         .level (lane_level),
         .rsp   (lane_rsp[ch])
      );

      assign lane_done[ch]    = lane_rsp[ch].done;
      assign lane_refresh[ch] = lane_rsp[ch].refresh;
   end

   if (spk_pkg::CHANNELS > 1) begin : g_pk_right
      assign peak_right_src = lane_rsp[1].peak;
   end else begin : g_pk_none
      assign peak_right_src = '0;
   end

   assign all_done = &(done_seen_ff | lane_done);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spk_pkg::T_IDLE: if (accept)   state_in = spk_pkg::T_RUN;
         spk_pkg::T_RUN:  if (all_done) state_in = spk_pkg::T_OUT;
         spk_pkg::T_OUT:  if (out_free) state_in = spk_pkg::T_IDLE;
         default:                       state_in = spk_pkg::T_IDLE;
      endcase
   end

   always_comb begin
      req_ready = state_ff == spk_pkg::T_IDLE;
      load_out  = (state_ff == spk_pkg::T_OUT) && out_free;
   end

   always_comb begin
      floor_in = floor_ff;
      hold_in  = hold_ff;
      rate_in  = rate_ff;
      if (csr_we) begin
         case (csr_index)
            spk_pkg::CSR_FLOOR_DB:   floor_in = csr_wdata;
            spk_pkg::CSR_HOLD_TIME:  hold_in  = csr_wdata;
            spk_pkg::CSR_DECAY_RATE: rate_in  = csr_wdata;
            default: begin
            end
         endcase
      end

      started_in     = started_ff;
      last_time_in   = last_time_ff;
      op_in          = op_ff;
      done_seen_in   = done_seen_ff | lane_done;
      refresh_acc_in = refresh_acc_ff | (|(lane_done & lane_refresh));
      if (accept) begin
         op_in          = req_opcode;
         done_seen_in   = '0;
         refresh_acc_in = 1'b0;
         if (level_op) begin
            started_in   = 1'b1;
            last_time_in = req_now_ms;
         end
      end

      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_peak_left_in  = rsp_peak_left_ff;
      rsp_peak_right_in = rsp_peak_right_ff;
      rsp_refresh_in    = rsp_refresh_ff;
      if (load_out) begin
         rsp_valid_in      = 1'b1;
         rsp_peak_left_in  = lane_rsp[0].peak;
         rsp_peak_right_in = peak_right_src;
         rsp_refresh_in    = refresh_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= spk_pkg::T_IDLE;
         floor_ff       <= spk_pkg::FLOOR_RESET;
         hold_ff        <= spk_pkg::HOLD_RESET;
         rate_ff        <= spk_pkg::DECAY_RESET;
         started_ff     <= 1'b0;
         last_time_ff   <= '0;
         done_seen_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         floor_ff       <= floor_in;
         hold_ff        <= hold_in;
         rate_ff        <= rate_in;
         started_ff     <= started_in;
         last_time_ff   <= last_time_in;
         done_seen_ff   <= done_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      refresh_acc_ff    <= refresh_acc_in;
      op_ff             <= op_in;
      rsp_peak_left_ff  <= rsp_peak_left_in;
      rsp_peak_right_ff <= rsp_peak_right_in;
      rsp_refresh_ff    <= rsp_refresh_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_peak_left  = rsp_peak_left_ff;
   assign rsp_peak_right = rsp_peak_right_ff;
   assign rsp_refresh    = rsp_refresh_ff;

   `SPHM_ASSERT_NOW(a_lane_done_in_run, clock, reset, |lane_done, state_ff == spk_pkg::T_RUN, "lane finished outside a request")
   `SPHM_ASSERT_NEXT(a_clear_result, clock, reset, load_out && (op_ff == spk_pkg::OP_CLEAR), (rsp_peak_left == '0) && (rsp_peak_right == '0) && rsp_refresh, "clear request returned nonzero peak")
   `SPHM_ASSERT_NEXT(a_started_sticky, clock, reset, started_ff, started_ff, "started flag dropped")

endmodule
